// ===== src/v3alu_pkg.sv =====
// shared types, opcodes and saturation helper for the vector alu
`default_nettype none

package v3alu_pkg;

    // field widths of the Q16.16 data path
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int OP_W   = 4;
    localparam int ST_W   = 2;

    // wide intermediate, square-root radicand and quotient widths
    localparam int WIDE_W = 2*DATA_W + 2;
    localparam int RAD_W  = 2*DATA_W;
    localparam int QUOT_W = DATA_W + FRAC_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd2;
    localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OP_W-1:0] OP_DOT   = 4'd5;
    localparam logic [OP_W-1:0] OP_CROSS = 4'd6;
    localparam logic [OP_W-1:0] OP_LEN   = 4'd7;
    localparam logic [OP_W-1:0] OP_NORM  = 4'd8;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

    // saturation bounds in the wide domain
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = ~WIDE_MAX;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic signed [DATA_W-1:0] first_x;
        logic signed [DATA_W-1:0] first_y;
        logic signed [DATA_W-1:0] first_z;
        logic signed [DATA_W-1:0] first_w;
        logic signed [DATA_W-1:0] second_x;
        logic signed [DATA_W-1:0] second_y;
        logic signed [DATA_W-1:0] second_z;
        logic signed [DATA_W-1:0] second_w;
        logic signed [DATA_W-1:0] scale_factor;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic signed [DATA_W-1:0] out_scalar;
        logic [ST_W-1:0]          status;
    } res_t;

    // saturated value with its overflow flag
    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } fit_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        fit_t              elem;
        logic [DATA_W-1:0] mag;
        logic              neg;
    } lane_out_t;

    // clamp a wide signed value to the field range
    function automatic fit_t sat_fit(input logic signed [WIDE_W-1:0] v);
        fit_t f;
        if (v > WIDE_MAX)
        begin
            f.sat = 1'b1;
            f.val = WIDE_MAX[DATA_W-1:0];
        end
        else if (v < WIDE_MIN)
        begin
            f.sat = 1'b1;
            f.val = WIDE_MIN[DATA_W-1:0];
        end
        else
        begin
            f.sat = 1'b0;
            f.val = v[DATA_W-1:0];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/v3alu_lane.sv =====
// one component lane: products, element-wise ops and magnitude for division
`default_nettype none

module v3alu_lane
    import v3alu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic [OP_W-1:0]          op,
    input  wire logic signed [DATA_W-1:0] a_i,
    input  wire logic signed [DATA_W-1:0] a_j,
    input  wire logic signed [DATA_W-1:0] a_k,
    input  wire logic signed [DATA_W-1:0] b_i,
    input  wire logic signed [DATA_W-1:0] b_j,
    input  wire logic signed [DATA_W-1:0] b_k,
    input  wire logic signed [DATA_W-1:0] s,
    output logic signed [2*DATA_W-1:0]    prod,
    output lane_out_t                     lane_out
);

    logic signed [DATA_W-1:0]   mul_l;
    logic signed [DATA_W-1:0]   mul_r;
    logic signed [DATA_W:0]     el_next;
    logic [DATA_W-1:0]          mag_next;

    logic [OP_W-1:0]            op_reg;
    logic signed [2*DATA_W-1:0] p0_reg;
    logic signed [2*DATA_W-1:0] p1_reg;
    logic signed [DATA_W:0]     el_reg;
    logic [DATA_W-1:0]          mag_reg;
    logic                       neg_reg;

    logic signed [2*DATA_W:0]   diff;
    fit_t                       elem;
    lane_out_t                  lane_out_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_l = (op == OP_CROSS) ? a_j : a_i;
        case (op)
            OP_SCALE: mul_r = s;
            OP_DOT:   mul_r = b_i;
            OP_CROSS: mul_r = b_k;
            default:  mul_r = a_i;
        endcase
    end

    // add, subtract and negate before the multiply stage
    always_comb
    begin
        case (op)
            OP_ADD:  el_next = $signed(a_i) + $signed(b_i);
            OP_SUB:  el_next = $signed(a_i) - $signed(b_i);
            OP_NEG:  el_next = -$signed((DATA_W+1)'(a_i));
            default: el_next = '0;
        endcase
        mag_next = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
    end

    // product stage
    always_ff @(posedge clk)
    begin
        op_reg  <= op;
        p0_reg  <= mul_l * mul_r;
        p1_reg  <= a_k * b_j;
        el_reg  <= el_next;
        mag_reg <= mag_next;
        neg_reg <= a_i[DATA_W-1];
    end

    // cross term difference, exact
    assign diff = (2*DATA_W+1)'(p0_reg) - (2*DATA_W+1)'(p1_reg);

    // per-element saturation
    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB, OP_NEG: elem = sat_fit(WIDE_W'(el_reg));
            OP_SCALE:               elem = sat_fit(WIDE_W'(p0_reg >>> FRAC_W));
            OP_CROSS:               elem = sat_fit(WIDE_W'(diff >>> FRAC_W));
            default:                elem = '0;
        endcase
    end

    // result stage
    always_ff @(posedge clk)
    begin
        lane_out_reg.elem <= elem;
        lane_out_reg.mag  <= mag_reg;
        lane_out_reg.neg  <= neg_reg;
    end

    assign prod     = p0_reg;
    assign lane_out = lane_out_reg;

endmodule

`default_nettype wire

// ===== src/v3alu_sqrt.sv =====
// pipelined floor square root, one result bit per stage
`default_nettype none

module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [RAD_W-1:0] rad,
    output logic [DATA_W-1:0]     root
);

    localparam int TRY_W = RAD_W + 1;

    logic [TRY_W-1:0]  rem_reg  [DATA_W-1];
    logic [DATA_W-1:0] root_reg [DATA_W];

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_step
        localparam int BIT_POS = DATA_W - 1 - k;

        logic [TRY_W-1:0]  rem_in;
        logic [TRY_W-1:0]  trial;
        logic [TRY_W-1:0]  rem_next;
        logic [DATA_W-1:0] root_in;
        logic [DATA_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = TRY_W'(rad);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // try setting this root bit: remainder minus (2*root + bit) * bit
        always_comb
        begin
            trial = (TRY_W'(root_in) << (BIT_POS + 1)) | (TRY_W'(1) << (2*BIT_POS));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (DATA_W'(1) << BIT_POS);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= root_next;
        end

        if (k < DATA_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign root = root_reg[DATA_W-1];

endmodule

`default_nettype wire

// ===== src/v3alu_div.sv =====
// pipelined restoring divider: (num << FRAC_W) / den, one quotient bit per stage
`default_nettype none

module v3alu_div
    import v3alu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic [QUOT_W-1:0]      quo
);

    logic [DATA_W-1:0] rem_reg [QUOT_W-1];
    logic [DATA_W-1:0] den_reg [QUOT_W-1];
    logic [QUOT_W-1:0] nq_reg  [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_step
        logic [DATA_W-1:0] rem_in;
        logic [DATA_W-1:0] den_in;
        logic [QUOT_W-1:0] nq_in;
        logic [DATA_W:0]   t;
        logic              ge;
        logic [DATA_W-1:0] rem_next;
        logic [QUOT_W-1:0] nq_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign den_in = den;
            assign nq_in  = {num, {FRAC_W{1'b0}}};
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign nq_in  = nq_reg[k-1];
        end

        // shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            t        = {rem_in, nq_in[QUOT_W-1]};
            ge       = (t >= {1'b0, den_in});
            rem_next = ge ? DATA_W'(t - {1'b0, den_in}) : t[DATA_W-1:0];
            nq_next  = {nq_in[QUOT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            nq_reg[k] <= nq_next;
        end

        if (k < QUOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = nq_reg[QUOT_W-1];

endmodule

`default_nettype wire

// ===== src/vector3_alu.sv =====
// top level of the homogeneous vector alu: lanes, merge, root and divider pipelines
`default_nettype none

// Fully pipelined Q16.16 vector unit. A request is taken in every cycle at which
// start is high; busy is always low. Every request, whatever its opcode, gives
// its result with done high in request order, after the input register, the
// lane product and result stages, the square root pipeline (32 stages, one root
// bit each), the divider pipeline (48 stages, one quotient bit each) that serves
// divide and normalize, and the result register; all other operations travel
// alongside them. The result is shown for one cycle only.
module vector3_alu
    import v3alu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output res_t      result
);

    localparam int LAT = 4 + DATA_W + QUOT_W;

    // request bundle carried beside the root pipeline
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [DATA_W-1:0]       ex;
        logic [DATA_W-1:0]       ey;
        logic [DATA_W-1:0]       ez;
        logic [DATA_W-1:0]       ew;
        logic [DATA_W-1:0]       esc;
        logic                    esat;
        logic [2:0][DATA_W-1:0]  mag;
        logic [2:0]              neg;
        logic [DATA_W-1:0]       smag;
        logic                    sneg;
    } side_t;

    // request bundle carried beside the divider pipeline
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] ex;
        logic [DATA_W-1:0] ey;
        logic [DATA_W-1:0] ez;
        logic [DATA_W-1:0] ew;
        logic [DATA_W-1:0] esc;
        logic              esat;
        logic [DATA_W-1:0] root;
        logic [2:0]        sgn;
        logic              zero;
    } side2_t;

    logic [LAT-1:0]             valid_reg;
    req_t                       req_reg;

    logic signed [DATA_W-1:0]   a_vec [3];
    logic signed [DATA_W-1:0]   b_vec [3];
    logic signed [2*DATA_W-1:0] prod  [3];
    lane_out_t                  lo    [3];

    logic signed [DATA_W:0]     w_next;
    logic [OP_W-1:0]            op_a_reg;
    logic signed [DATA_W:0]     w_a_reg;
    logic [DATA_W-1:0]          smag_a_reg;
    logic                       sneg_a_reg;

    logic signed [WIDE_W-1:0]   dot_sum;
    fit_t                       w_fit;
    fit_t                       dot_fit;
    logic [OP_W-1:0]            op_b_reg;
    fit_t                       w_b_reg;
    fit_t                       dot_b_reg;
    logic [RAD_W-1:0]           rad_b_reg;
    logic [DATA_W-1:0]          smag_b_reg;
    logic                       sneg_b_reg;

    side_t                      side_b;
    side_t                      side_d [DATA_W];
    logic [DATA_W-1:0]          root;
    side_t                      side_s;
    logic [DATA_W-1:0]          den;
    side2_t                     side2_in;
    side2_t                     side2_d [QUOT_W];
    logic [QUOT_W-1:0]          quo [3];

    side2_t                     fin;
    logic signed [WIDE_W-1:0]   qs  [3];
    fit_t                       qf  [3];
    fit_t                       lf;
    res_t                       res_next;
    res_t                       result_reg;

    // request strobe pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start && !busy};
    end

    // input register
    always_ff @(posedge clk)
    begin
        req_reg <= req;
    end

    assign a_vec[0] = req_reg.first_x;
    assign a_vec[1] = req_reg.first_y;
    assign a_vec[2] = req_reg.first_z;
    assign b_vec[0] = req_reg.second_x;
    assign b_vec[1] = req_reg.second_y;
    assign b_vec[2] = req_reg.second_z;

    // x, y and z lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        v3alu_lane u_lane (
            .clk      (clk),
            .op       (req_reg.req_type),
            .a_i      (a_vec[i]),
            .a_j      (a_vec[(i+1)%3]),
            .a_k      (a_vec[(i+2)%3]),
            .b_i      (b_vec[i]),
            .b_j      (b_vec[(i+1)%3]),
            .b_k      (b_vec[(i+2)%3]),
            .s        (req_reg.scale_factor),
            .prod     (prod[i]),
            .lane_out (lo[i])
        );
    end

    // w component and scalar magnitude
    always_comb
    begin
        case (req_reg.req_type)
            OP_ADD:  w_next = $signed(req_reg.first_w) + $signed(req_reg.second_w);
            OP_SUB:  w_next = $signed(req_reg.first_w) - $signed(req_reg.second_w);
            OP_NEG:  w_next = (DATA_W+1)'($signed(req_reg.first_w));
            default: w_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_a_reg   <= req_reg.req_type;
        w_a_reg    <= w_next;
        smag_a_reg <= req_reg.scale_factor[DATA_W-1] ?
                      DATA_W'(-req_reg.scale_factor) : DATA_W'(req_reg.scale_factor);
        sneg_a_reg <= req_reg.scale_factor[DATA_W-1];
    end

    // merge: sum of lane products for dot and for the squared length
    assign dot_sum = WIDE_W'(prod[0]) + WIDE_W'(prod[1]) + WIDE_W'(prod[2]);

    always_comb
    begin
        case (op_a_reg)
            OP_ADD, OP_SUB: w_fit = sat_fit(WIDE_W'(w_a_reg));
            OP_NEG:         w_fit = {1'b0, w_a_reg[DATA_W-1:0]};
            default:        w_fit = '0;
        endcase
        dot_fit = (op_a_reg == OP_DOT) ? sat_fit(dot_sum >>> FRAC_W) : '0;
    end

    always_ff @(posedge clk)
    begin
        op_b_reg   <= op_a_reg;
        w_b_reg    <= w_fit;
        dot_b_reg  <= dot_fit;
        rad_b_reg  <= dot_sum[RAD_W-1:0];
        smag_b_reg <= smag_a_reg;
        sneg_b_reg <= sneg_a_reg;
    end

    // gather the merged request bundle
    always_comb
    begin
        side_b.op   = op_b_reg;
        side_b.ex   = lo[0].elem.val;
        side_b.ey   = lo[1].elem.val;
        side_b.ez   = lo[2].elem.val;
        side_b.ew   = w_b_reg.val;
        side_b.esc  = dot_b_reg.val;
        side_b.esat = lo[0].elem.sat | lo[1].elem.sat | lo[2].elem.sat
                    | w_b_reg.sat | dot_b_reg.sat;
        side_b.mag  = {lo[2].mag, lo[1].mag, lo[0].mag};
        side_b.neg  = {lo[2].neg, lo[1].neg, lo[0].neg};
        side_b.smag = smag_b_reg;
        side_b.sneg = sneg_b_reg;
    end

    // length pipeline
    v3alu_sqrt u_sqrt (
        .clk  (clk),
        .rad  (rad_b_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        side_d[0] <= side_b;
        for (int k = 1; k < DATA_W; k++)
        begin
            side_d[k] <= side_d[k-1];
        end
    end

    assign side_s = side_d[DATA_W-1];

    // divisor: scalar magnitude or unsaturated length
    always_comb
    begin
        den           = (side_s.op == OP_NORM) ? root : side_s.smag;
        side2_in.op   = side_s.op;
        side2_in.ex   = side_s.ex;
        side2_in.ey   = side_s.ey;
        side2_in.ez   = side_s.ez;
        side2_in.ew   = side_s.ew;
        side2_in.esc  = side_s.esc;
        side2_in.esat = side_s.esat;
        side2_in.root = root;
        side2_in.sgn  = (side_s.op == OP_NORM) ? side_s.neg : (side_s.neg ^ {3{side_s.sneg}});
        side2_in.zero = (den == '0);
    end

    // quotient lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        v3alu_div u_div (
            .clk (clk),
            .num (side_s.mag[i]),
            .den (den),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        side2_d[0] <= side2_in;
        for (int k = 1; k < QUOT_W; k++)
        begin
            side2_d[k] <= side2_d[k-1];
        end
    end

    assign fin = side2_d[QUOT_W-1];

    // signed, saturated quotients and length
    for (genvar i = 0; i < 3; i++)
    begin : g_qfit
        assign qs[i] = fin.sgn[i] ? -$signed(WIDE_W'(quo[i])) : $signed(WIDE_W'(quo[i]));
        assign qf[i] = sat_fit(qs[i]);
    end

    assign lf = sat_fit($signed(WIDE_W'(fin.root)));

    // final result select
    always_comb
    begin
        res_next = '0;
        case (fin.op)
            OP_DIV, OP_NORM:
            begin
                if (fin.zero)
                begin
                    res_next.status = ST_DIVZ;
                end
                else
                begin
                    res_next.out_x  = qf[0].val;
                    res_next.out_y  = qf[1].val;
                    res_next.out_z  = qf[2].val;
                    res_next.status = (qf[0].sat | qf[1].sat | qf[2].sat) ? ST_SAT : ST_OK;
                end
            end
            OP_LEN:
            begin
                res_next.out_scalar = lf.val;
                res_next.status     = lf.sat ? ST_SAT : ST_OK;
            end
            default:
            begin
                res_next.out_x      = fin.ex;
                res_next.out_y      = fin.ey;
                res_next.out_z      = fin.ez;
                res_next.out_w      = fin.ew;
                res_next.out_scalar = fin.esc;
                res_next.status     = fin.esat ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign busy   = 1'b0;
    assign done   = valid_reg[LAT-1];
    assign result = result_reg;

`ifndef SYNTHESIS
    // every taken request comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not complete after fixed latency");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result strobe without a request");

    // a zero divisor gives an all-zero result
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DIVZ) |->
        (result.out_x == '0 && result.out_y == '0 && result.out_z == '0 &&
         result.out_w == '0 && result.out_scalar == '0))
        else $error("divide by zero result not cleared");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/vector3_alu_test.sv =====
// self-checking testbench for the Q16.16 homogeneous vector alu
`default_nettype none

module vector3_alu_test
    import v3alu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RST_CYCLES  = 11;
    localparam int IDLE_LIMIT  = 600;
    localparam int DRAIN_WAIT  = 100;
    localparam int RAND_ITEMS  = 1820;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t result;

    res_t expected_q[$];
    int   n_sent;
    int   n_checked;
    int   n_errors;
    int   idle_cycles;
    int   op_count[16];
    bit   no_gaps;

    vector3_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // clamp a wide value to the field range, flagging overflow
    function automatic logic [DATA_W:0] clamp_q(input logic signed [127:0] v);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = 128'sd2147483647;
        lo_lim = -128'sd2147483648;
        if (v > hi_lim)
            return {1'b1, hi_lim[DATA_W-1:0]};
        else if (v < lo_lim)
            return {1'b1, lo_lim[DATA_W-1:0]};
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // floor square root of an unsigned radicand
    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0] acc;
        logic [63:0] c;
        acc = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = acc | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                acc = c;
        end
        return acc;
    endfunction

    // quotient (num << FRAC_W) / den truncated toward zero
    function automatic logic signed [127:0] quot_q(input logic signed [127:0] num,
                                                   input logic [127:0] den_mag,
                                                   input bit den_neg);
        logic [127:0] q;
        q = (abs_wide(num) << FRAC_W) / den_mag;
        return ((num < 0) != den_neg) ? -$signed(q) : $signed(q);
    endfunction

    // expected result of one request
    function automatic res_t vector_result(input req_t r);
        logic signed [127:0] a [4];
        logic signed [127:0] b [4];
        logic signed [127:0] s;
        logic signed [127:0] t;
        logic [127:0]        radicand;
        logic [63:0]         len;
        logic [DATA_W:0]     f [5];
        logic                sat;
        logic [ST_W-1:0]     st;
        logic [DATA_W-1:0]   keep_w;
        res_t                o;
        a[0] = r.first_x;  a[1] = r.first_y;  a[2] = r.first_z;  a[3] = r.first_w;
        b[0] = r.second_x; b[1] = r.second_y; b[2] = r.second_z; b[3] = r.second_w;
        s = r.scale_factor;
        for (int i = 0; i < 5; i++)
            f[i] = '0;
        st = ST_OK;
        keep_w = '0;
        case (r.req_type)
            OP_ADD:
                for (int i = 0; i < 4; i++) f[i] = clamp_q(a[i] + b[i]);
            OP_SUB:
                for (int i = 0; i < 4; i++) f[i] = clamp_q(a[i] - b[i]);
            OP_NEG:
            begin
                for (int i = 0; i < 3; i++) f[i] = clamp_q(-a[i]);
                keep_w = r.first_w;
            end
            OP_SCALE:
                for (int i = 0; i < 3; i++) f[i] = clamp_q((a[i] * s) >>> FRAC_W);
            OP_DIV:
                if (s == 0)
                    st = ST_DIVZ;
                else
                    for (int i = 0; i < 3; i++)
                        f[i] = clamp_q(quot_q(a[i], abs_wide(s), s < 0));
            OP_DOT:
            begin
                t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                f[4] = clamp_q(t >>> FRAC_W);
            end
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                begin
                    t = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
                    f[i] = clamp_q(t >>> FRAC_W);
                end
            OP_LEN, OP_NORM:
            begin
                radicand = '0;
                for (int i = 0; i < 3; i++)
                    radicand += abs_wide(a[i]) * abs_wide(a[i]);
                len = root_floor(radicand);
                if (r.req_type == OP_LEN)
                    f[4] = clamp_q($signed({64'd0, len}));
                else if (len == 0)
                    st = ST_DIVZ;
                else
                    for (int i = 0; i < 3; i++)
                        f[i] = clamp_q(quot_q(a[i], {64'd0, len}, 1'b0));
            end
            default:
                ;
        endcase
        sat = f[0][DATA_W] | f[1][DATA_W] | f[2][DATA_W] | f[3][DATA_W] | f[4][DATA_W];
        if (st == ST_OK && sat)
            st = ST_SAT;
        o.out_x      = f[0][DATA_W-1:0];
        o.out_y      = f[1][DATA_W-1:0];
        o.out_z      = f[2][DATA_W-1:0];
        o.out_w      = (r.req_type == OP_NEG) ? keep_w : f[3][DATA_W-1:0];
        o.out_scalar = f[4][DATA_W-1:0];
        o.status     = st;
        return o;
    endfunction

    // mismatch report for one field
    task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // compare each result with the oldest pending expectation
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && done === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with no pending request, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                e = expected_q.pop_front();
                report_field("out_x", e.out_x, result.out_x);
                report_field("out_y", e.out_y, result.out_y);
                report_field("out_z", e.out_z, result.out_z);
                report_field("out_w", e.out_w, result.out_w);
                report_field("out_scalar", e.out_scalar, result.out_scalar);
                report_field("status", DATA_W'(e.status), DATA_W'(result.status));
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("vector3_alu_test: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one request, called at a rising edge
    task automatic send_req(input req_t r);
        int gap;
        req   <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        expected_q.push_back(vector_result(r));
        n_sent++;
        op_count[r.req_type]++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random Q value, biased toward extremes and small magnitudes
    function automatic logic [DATA_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 5))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0000_0000;
                   3: return 32'hffff_ffff;
                   4: return 32'h0001_0000;
                   default: return 32'hffff_0000;
               endcase
            1, 2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            5: return $urandom_range(0, 32'h0000_ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req(input logic [OP_W-1:0] op);
        req_t r;
        r.req_type     = op;
        r.first_x      = rand_q();
        r.first_y      = rand_q();
        r.first_z      = rand_q();
        r.first_w      = rand_q();
        r.second_x     = rand_q();
        r.second_y     = rand_q();
        r.second_z     = rand_q();
        r.second_w     = rand_q();
        r.scale_factor = rand_q();
        if ((op == OP_NORM || op == OP_LEN) && $urandom_range(0, 19) == 0)
        begin
            r.first_x = '0; r.first_y = '0; r.first_z = '0;
        end
        return r;
    endfunction

    function automatic req_t fill_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                                      input logic [DATA_W-1:0] s);
        req_t r;
        r = '{op, v, v, v, v, v, v, v, v, s};
        return r;
    endfunction

    // extremes, every opcode and the named corner cases
    task automatic test_directed();
        req_t r;
        send_req(fill_req(OP_ADD, 32'h7fff_ffff, 0));
        send_req(fill_req(OP_ADD, 32'h8000_0000, 0));
        send_req(fill_req(OP_SUB, 32'h8000_0000, 0));
        r = fill_req(OP_SUB, 32'h8000_0000, 0);
        r.second_x = 32'h0000_0001;
        send_req(r);
        send_req(fill_req(OP_NEG, 32'h8000_0000, 0));
        send_req(fill_req(OP_NEG, 32'h0001_8000, 0));
        send_req(fill_req(OP_SCALE, 32'h7fff_ffff, 32'h7fff_ffff));
        send_req(fill_req(OP_SCALE, 32'hfffe_0000, 32'h0000_8000));
        send_req(fill_req(OP_DIV, 32'h0003_0000, 32'h0000_0000));
        send_req(fill_req(OP_DIV, 32'h8000_0000, 32'hffff_ffff));
        send_req(fill_req(OP_DIV, 32'hfffd_0000, 32'h0002_0000));
        send_req(fill_req(OP_DOT, 32'h8000_0000, 0));
        send_req(fill_req(OP_DOT, 32'h0002_0000, 0));
        send_req(rand_req(OP_CROSS));
        send_req(fill_req(OP_CROSS, 32'h8000_0000, 0));
        send_req(fill_req(OP_LEN, 32'h8000_0000, 0));
        send_req(fill_req(OP_LEN, 32'h0003_0000, 0));
        send_req(fill_req(OP_NORM, 32'h0000_0000, 0));
        send_req(fill_req(OP_NORM, 32'h0000_0001, 0));
        send_req(fill_req(OP_NORM, 32'h8000_0000, 0));
        send_req(fill_req(4'd9, 32'h1234_5678, 1));
        send_req(fill_req(4'd15, 32'hffff_ffff, 1));
    endtask

    // sender holds off until every pending result is back
    task automatic test_drain_pause();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        send_req(rand_req(OP_NORM));
    endtask

    // back-to-back stretch with no idling
    task automatic test_burst(input int count);
        no_gaps = 1'b1;
        repeat (count) send_req(rand_req(OP_W'($urandom_range(0, 8))));
        no_gaps = 1'b0;
    endtask

    // random mix, mostly valid opcodes
    task automatic test_random(input int count);
        logic [OP_W-1:0] op;
        repeat (count)
        begin
            op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(9, 15))
                                              : OP_W'($urandom_range(0, 8));
            send_req(rand_req(op));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        no_gaps     = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_random(RAND_ITEMS / 2);
        test_burst(200);
        test_drain_pause();
        test_random(RAND_ITEMS / 2 - 200);

        // drain
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("requests sent %0d, results checked %0d, mismatches %0d",
                 n_sent, n_checked, n_errors);
        $display("per opcode: add %0d sub %0d neg %0d scale %0d div %0d dot %0d "
                 , op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5], "cross %0d len %0d norm %0d", op_count[6], op_count[7],
                 op_count[8]);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("vector3_alu_test: done, clean");
        else
            $display("vector3_alu_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/v3alu_pkg.sv
src/v3alu_lane.sv
src/v3alu_sqrt.sv
src/v3alu_div.sv
src/vector3_alu.sv
tb/sv/vector3_alu_test.sv
